>>> design/llrc_pkg.sv
`default_nettype none
package llrc_pkg;

	localparam int unsigned PIXEL_W     = 8;
	localparam int unsigned ROW_INDEX_W = 10;
	localparam int unsigned CENTROID_W  = 14;

	// threshold after reset
	localparam logic [PIXEL_W-1:0] THR_RESET = 8'd10;

	// controller to datapath
	typedef struct packed {
		logic pix_take;
		logic best_clr;
		logic div_load;
		logic div_step;
		logic rd_en;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic best_found;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> design/llrc_if.sv
`default_nettype none
interface llrc_pixel_if;
	logic                           valid;
	logic                           ready;
	logic [llrc_pkg::PIXEL_W-1:0]   cur_pixel;
	logic [llrc_pkg::PIXEL_W-1:0]   ref_pixel;
	logic                           frame_start;
	logic                           row_end;

	modport source (output valid, cur_pixel, ref_pixel, frame_start, row_end, input ready);
	modport sink (input valid, cur_pixel, ref_pixel, frame_start, row_end, output ready);
endinterface

interface llrc_result_if;
	logic                              valid;
	logic                              ready;
	logic [llrc_pkg::ROW_INDEX_W-1:0]  row_index;
	logic [llrc_pkg::CENTROID_W-1:0]   centroid_q4;
	logic [llrc_pkg::PIXEL_W-1:0]      ref_value;

	modport source (output valid, row_index, centroid_q4, ref_value, input ready);
	modport sink (input valid, row_index, centroid_q4, ref_value, output ready);
endinterface

interface llrc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [llrc_pkg::PIXEL_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> design/llrc_ctrl.sv
`default_nettype none
module llrc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pixel_valid,
	input  wire logic           row_end,
	output logic                pixel_ready,
	input  wire llrc_pkg::sts_t sts,
	output llrc_pkg::cmd_t      cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FIN  = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;
	localparam logic [2:0] S_LOAD = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_n;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.pix_take = pixel_valid;
				if (pixel_valid && row_end) begin
					state_n = S_FIN;
				end
			end
			// last candidate of the row merges here
			S_FIN: begin
				state_n = S_CHK;
			end
			S_CHK: begin
				cmd.best_clr = 1'b1;
				if (sts.best_found) begin
					cmd.div_load = 1'b1;
					state_n      = S_DIV;
				end else begin
					state_n = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_n = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_n   = S_LOAD;
			end
			S_LOAD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign pixel_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	a_rowend_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pix_take && row_end) |=> (state_q == S_FIN))
		else $error("row end beat did not start row closing");

	a_div_needs_best: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |-> sts.best_found)
		else $error("divider started without a cluster");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result overwritten before taken");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |=> !cmd.pix_take)
		else $error("pixel taken during division");

endmodule
`default_nettype wire

>>> design/llrc_datapath.sv
`default_nettype none
module llrc_datapath #(
	parameter int unsigned MAX_COLUMNS = 1024,
	parameter int unsigned MAX_ROWS    = 1024,
	parameter int unsigned FRAC_BITS   = 4
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire llrc_pkg::cmd_t                       cmd,
	output llrc_pkg::sts_t                            sts,
	input  wire logic                                 cfg_valid,
	input  wire logic [llrc_pkg::PIXEL_W-1:0]         cfg_data,
	input  wire logic [llrc_pkg::PIXEL_W-1:0]         cur_pixel,
	input  wire logic [llrc_pkg::PIXEL_W-1:0]         ref_pixel,
	input  wire logic                                 frame_start,
	input  wire logic                                 row_end,
	output logic                                      res_valid,
	input  wire logic                                 res_ready,
	output logic [llrc_pkg::ROW_INDEX_W-1:0]          row_index,
	output logic [llrc_pkg::CENTROID_W-1:0]           centroid_q4,
	output logic [llrc_pkg::PIXEL_W-1:0]              ref_value
);

	localparam int unsigned COL_W  = $clog2(MAX_COLUMNS);
	localparam int unsigned LEN_W  = $clog2(MAX_COLUMNS + 1);
	localparam int unsigned SUM_W  = $clog2(255 * MAX_COLUMNS + 1);
	localparam int unsigned WSUM_W = SUM_W + COL_W;
	localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned QW     = COL_W + FRAC_BITS;
	localparam int unsigned DVD_W  = WSUM_W + FRAC_BITS;
	localparam int unsigned PROD_W = SUM_W + LEN_W;
	localparam int unsigned CNT_W  = $clog2(QW);
	localparam int unsigned PW     = llrc_pkg::PIXEL_W;
	localparam int unsigned RIW    = llrc_pkg::ROW_INDEX_W;
	localparam int unsigned CW     = llrc_pkg::CENTROID_W;

	logic [PW-1:0]     thr_q;
	logic [LEN_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  res_row_q;
	logic              in_run_q;
	logic [SUM_W-1:0]  run_sum_q;
	logic [WSUM_W-1:0] run_wsum_q;
	logic [LEN_W-1:0]  run_len_q;
	logic              cand_v_q;
	logic [SUM_W-1:0]  cand_sum_q;
	logic [WSUM_W-1:0] cand_wsum_q;
	logic [LEN_W-1:0]  cand_len_q;
	logic              best_found_q;
	logic [SUM_W-1:0]  best_sum_q;
	logic [WSUM_W-1:0] best_wsum_q;
	logic [LEN_W-1:0]  best_len_q;
	logic [SUM_W-1:0]  div_rem_q;
	logic [QW-1:0]     div_acc_q;
	logic [SUM_W-1:0]  div_sor_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic [PW-1:0]     rd_data_q;
	logic              out_v_q;
	logic [RIW-1:0]    out_row_q;
	logic [CW-1:0]     out_cent_q;
	logic [PW-1:0]     out_ref_q;
	logic [PW-1:0]     ref_mem [MAX_COLUMNS];

	// pixel stage
	logic [PW:0]         diff9;
	logic                hit;
	logic [PW-1:0]       d;
	logic [LEN_W-1:0]    col_b;
	logic [ROW_W-1:0]    row_b;
	logic                active;
	logic [COL_W-1:0]    col_idx;
	logic                is_nz;
	logic                run_in_b;
	logic [SUM_W-1:0]    run_sum_b;
	logic [WSUM_W-1:0]   run_wsum_b;
	logic [LEN_W-1:0]    run_len_b;
	logic [COL_W+PW-1:0] wprod;
	logic                run_in_a;
	logic [SUM_W-1:0]    run_sum_a;
	logic [WSUM_W-1:0]   run_wsum_a;
	logic [LEN_W-1:0]    run_len_a;
	logic                close;
	logic                take_fs;

	assign take_fs  = cmd.pix_take && frame_start;
	assign diff9    = {1'b0, cur_pixel} - {1'b0, ref_pixel};
	assign hit      = !diff9[PW] && (diff9[PW-1:0] > thr_q);
	assign d        = hit ? diff9[PW-1:0] : '0;
	assign col_b    = frame_start ? '0 : col_q;
	assign row_b    = frame_start ? '0 : row_q;
	assign active   = col_b < LEN_W'(MAX_COLUMNS);
	assign col_idx  = col_b[COL_W-1:0];
	assign is_nz    = active && hit;
	assign run_in_b   = frame_start ? 1'b0 : in_run_q;
	assign run_sum_b  = frame_start ? '0 : run_sum_q;
	assign run_wsum_b = frame_start ? '0 : run_wsum_q;
	assign run_len_b  = frame_start ? '0 : run_len_q;
	assign wprod      = d * col_idx;
	assign run_in_a   = run_in_b || is_nz;
	assign run_sum_a  = is_nz ? run_sum_b + {{(SUM_W-PW){1'b0}}, d} : run_sum_b;
	assign run_wsum_a = is_nz ? run_wsum_b + {{(WSUM_W-COL_W-PW){1'b0}}, wprod} : run_wsum_b;
	assign run_len_a  = is_nz ? run_len_b + LEN_W'(1) : run_len_b;
	assign close      = run_in_a && ((active && !hit) || row_end);

	// cluster compare, in the cycle after the cluster closes
	logic [PROD_W-1:0] prod_cand;
	logic [PROD_W-1:0] prod_best;
	logic              better;
	logic              merge_en;

	assign prod_cand = cand_sum_q * best_len_q;
	assign prod_best = best_sum_q * cand_len_q;
	assign better    = !best_found_q || (prod_cand > prod_best);
	assign merge_en  = cand_v_q && !take_fs;

	// restoring divider step
	logic [DVD_W-1:0] dvd;
	logic [SUM_W:0]   trial;
	logic [SUM_W:0]   trial_sub;
	logic             ge;

	assign dvd       = DVD_W'(best_wsum_q) << FRAC_BITS;
	assign trial     = {div_rem_q, div_acc_q[QW-1]};
	assign trial_sub = trial - {1'b0, div_sor_q};
	assign ge        = trial >= {1'b0, div_sor_q};

	logic [ROW_W+RIW-1:0] row_ext;
	logic [QW+CW-1:0]     cent_ext;

	assign row_ext  = {{RIW{1'b0}}, res_row_q};
	assign cent_ext = {{CW{1'b0}}, div_acc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= llrc_pkg::THR_RESET;
			col_q        <= '0;
			row_q        <= '0;
			in_run_q     <= 1'b0;
			run_sum_q    <= '0;
			run_wsum_q   <= '0;
			run_len_q    <= '0;
			cand_v_q     <= 1'b0;
			best_found_q <= 1'b0;
			div_cnt_q    <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end

			cand_v_q <= cmd.pix_take && close;
			if (cmd.pix_take) begin
				if (close) begin
					in_run_q   <= 1'b0;
					run_sum_q  <= '0;
					run_wsum_q <= '0;
					run_len_q  <= '0;
				end else begin
					in_run_q   <= run_in_a;
					run_sum_q  <= run_sum_a;
					run_wsum_q <= run_wsum_a;
					run_len_q  <= run_len_a;
				end
				if (row_end) begin
					col_q <= '0;
					if (row_b != ROW_W'(MAX_ROWS - 1)) begin
						row_q <= row_b + ROW_W'(1);
					end else begin
						row_q <= row_b;
					end
				end else begin
					col_q <= active ? col_b + LEN_W'(1) : col_b;
					row_q <= row_b;
				end
			end

			if (cmd.best_clr || take_fs) begin
				best_found_q <= 1'b0;
			end else if (merge_en && better) begin
				best_found_q <= 1'b1;
			end

			if (cmd.div_load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + CNT_W'(1);
			end

			if (cmd.out_load) begin
				out_v_q <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.pix_take && close) begin
			cand_sum_q  <= run_sum_a;
			cand_wsum_q <= run_wsum_a;
			cand_len_q  <= run_len_a;
		end
		if (cmd.pix_take && row_end) begin
			res_row_q <= row_b;
		end
		if (merge_en && better) begin
			best_sum_q  <= cand_sum_q;
			best_wsum_q <= cand_wsum_q;
			best_len_q  <= cand_len_q;
		end
		if (cmd.div_load) begin
			div_rem_q <= dvd[DVD_W-1:QW];
			div_acc_q <= dvd[QW-1:0];
			div_sor_q <= best_sum_q;
		end else if (cmd.div_step) begin
			div_rem_q <= ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
			div_acc_q <= {div_acc_q[QW-2:0], ge};
		end
		if (cmd.out_load) begin
			out_row_q  <= row_ext[RIW-1:0];
			out_cent_q <= cent_ext[CW-1:0];
			out_ref_q  <= rd_data_q;
		end
	end

	// reference line of the current row
	always_ff @(posedge clk) begin
		if (cmd.pix_take && active) begin
			ref_mem[col_idx] <= ref_pixel;
		end
		if (cmd.rd_en) begin
			rd_data_q <= ref_mem[div_acc_q[QW-1:FRAC_BITS]];
		end
	end

	assign sts.best_found = best_found_q;
	assign sts.div_last   = (div_cnt_q == CNT_W'(QW - 1));
	assign sts.out_free   = !out_v_q || res_ready;

	assign res_valid   = out_v_q;
	assign row_index   = out_row_q;
	assign centroid_q4 = out_cent_q;
	assign ref_value   = out_ref_q;

endmodule
`default_nettype wire

>>> design/laser_line_row_centroid.sv
`default_nettype none
// Laser line row centroid: takes one pixel beat per clock (current and reference
// gray value plus frame_start/row_end marks), keeps cur-ref where it exceeds the
// threshold register (reset 10), groups nonzero differences of a row into
// clusters and on the row end reports the cluster with the highest mean as
// row_index, centroid_q4 = floor(2^FRAC_BITS * sum(d*col) / sum(d)) and the
// reference pixel at the integer column of that centroid. Rows without a cluster
// give no result beat. Within a row pixels are taken back to back, one per
// clock. After a row_end beat the input stalls while the row is closed: the
// merge and check of the last cluster, then for a row with a cluster the
// restoring divider, which produces one quotient bit per clock, the registered
// read of the reference line memory and a wait while the previous result still
// waits at the output. The threshold is written through cfg, which is always
// ready; write it only while the block is idle.
module laser_line_row_centroid #(
	parameter int unsigned MAX_COLUMNS = 1024,
	parameter int unsigned MAX_ROWS    = 1024,
	parameter int unsigned FRAC_BITS   = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	llrc_pixel_if.sink    pixel,
	llrc_result_if.source result,
	llrc_cfg_if.sink      cfg
);

	// command and status between the sequencer and the datapath
	llrc_pkg::cmd_t cmd;
	llrc_pkg::sts_t sts;
	logic           pixel_ready;

	// threshold register takes every beat
	assign cfg.ready   = 1'b1;
	assign pixel.ready = pixel_ready;

	// row closing sequencer: pixel intake, merge, divide, memory read, output load
	llrc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel.valid),
		.row_end     (pixel.row_end),
		.pixel_ready (pixel_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	// accumulators, cluster compare, divider, reference line and result register
	llrc_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.FRAC_BITS   (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg.valid),
		.cfg_data    (cfg.data),
		.cur_pixel   (pixel.cur_pixel),
		.ref_pixel   (pixel.ref_pixel),
		.frame_start (pixel.frame_start),
		.row_end     (pixel.row_end),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.row_index   (result.row_index),
		.centroid_q4 (result.centroid_q4),
		.ref_value   (result.ref_value)
	);

endmodule
`default_nettype wire

>>> sim/tb_laser_line_row_centroid.sv
`default_nettype none
module tb_laser_line_row_centroid;

	typedef logic [llrc_pkg::PIXEL_W-1:0]     pix_t;
	typedef logic [llrc_pkg::ROW_INDEX_W-1:0] row_idx_t;
	typedef logic [llrc_pkg::CENTROID_W-1:0]  cent_t;

	// geometry of the block under test, kept at its defaults
	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int FRAC_BITS   = 4;
	localparam pix_t THR_DEFAULT = llrc_pkg::THR_RESET;

	// quiet time after the owed centroids, ample for a row close plus the output wait
	localparam int SETTLE_CYCLES  = 40;
	// receiver hold-off long enough to back the block up into its input
	localparam int HOLD_CYCLES    = 400;
	// cycles without any beat moving before the run is declared hung
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		pix_t cur_pixel;
		pix_t ref_pixel;
		logic frame_start;
		logic row_end;
	} pixel_beat_t;

	typedef struct packed {
		row_idx_t row_index;
		cent_t    centroid_q4;
		pix_t     ref_value;
	} centroid_beat_t;

	// how a pixel beat's outcome is checked
	typedef enum logic [1:0] {
		CHK_MODEL,   // whatever the predictor works out
		CHK_NONE,    // no centroid may come from this beat
		CHK_TYPED    // the centroid written into the table
	} chk_kind_t;

	typedef struct {
		pixel_beat_t    beat;
		chk_kind_t      chk;
		centroid_beat_t typed;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	llrc_pixel_if  pix_ch ();
	llrc_result_if res_ch ();
	llrc_cfg_if    cfg_ch ();

	laser_line_row_centroid u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// row centroid predictor: threshold register and per-row state
	// ---------------------------------------------------------------
	pix_t                   thr_reg;
	int unsigned            col_cnt;
	row_idx_t               row_cnt;
	bit                     in_run;
	logic [17:0]            run_sum;
	logic [27:0]            run_wsum;
	logic [10:0]            run_len;
	bit                     best_found;
	logic [17:0]            best_sum;
	logic [27:0]            best_wsum;
	logic [10:0]            best_len;
	pix_t                   row_refs [MAX_COLUMNS];

	// centroids still owed by the block, oldest first
	centroid_beat_t pending_centroids [$];

	dir_row_t directed_tbl [$];

	int unsigned fail_cnt    = 0;
	int unsigned items_sent  = 0;
	int          idle_pct    = 0;   // sender gap odds, percent per beat
	int          stall_pct   = 0;   // receiver stall odds, percent per cycle
	int unsigned hold_req_cnt = 0;  // bumped to ask the receiver for a long hold

	function automatic void clear_row();
		col_cnt    = 0;
		in_run     = 1'b0;
		run_sum    = '0;
		run_wsum   = '0;
		run_len    = '0;
		best_found = 1'b0;
		best_sum   = '0;
		best_wsum  = '0;
		best_len   = '0;
	endfunction

	// close the open cluster; it replaces the best only on a strictly higher
	// mean, compared cross-multiplied, so the earlier cluster keeps a tie
	function automatic void close_cluster();
		logic [63:0] lhs;
		logic [63:0] rhs;
		if (in_run) begin
			lhs = 64'(run_sum) * 64'(best_len);
			rhs = 64'(best_sum) * 64'(run_len);
			if (!best_found || lhs > rhs) begin
				best_found = 1'b1;
				best_sum   = run_sum;
				best_wsum  = run_wsum;
				best_len   = run_len;
			end
			in_run   = 1'b0;
			run_sum  = '0;
			run_wsum = '0;
			run_len  = '0;
		end
	endfunction

	function automatic bit predict_centroid(input pixel_beat_t b, output centroid_beat_t r);
		pix_t               d;
		logic [63:0]        wsum;
		logic [63:0]        quo;
		logic [63:0]        ipart;
		bit                 hit;
		hit = 1'b0;
		r   = '0;
		// frame start drops the row under way before this pixel counts
		if (b.frame_start) begin
			row_cnt = '0;
			clear_row();
		end
		// columns past the line width are neither stored nor summed
		if (col_cnt < MAX_COLUMNS) begin
			d = '0;
			if (b.cur_pixel > b.ref_pixel && b.cur_pixel - b.ref_pixel > thr_reg)
				d = b.cur_pixel - b.ref_pixel;
			row_refs[col_cnt] = b.ref_pixel;
			if (d != 0) begin
				in_run   = 1'b1;
				run_sum  = run_sum + 18'(d);
				run_wsum = run_wsum + 28'(d * col_cnt);
				run_len  = run_len + 11'(1);
			end else begin
				close_cluster();
			end
			col_cnt++;
		end
		if (b.row_end) begin
			close_cluster();
			if (best_found && best_sum != 0) begin
				wsum          = 64'(best_wsum);
				quo           = (wsum << FRAC_BITS) / 64'(best_sum);
				ipart         = wsum / 64'(best_sum);
				r.row_index   = row_cnt;
				r.centroid_q4 = quo[llrc_pkg::CENTROID_W-1:0];
				r.ref_value   = row_refs[ipart[9:0]];
				hit           = 1'b1;
			end
			// row counter sticks at the last row
			if (int'(row_cnt) < MAX_ROWS - 1)
				row_cnt = row_cnt + row_idx_t'(1);
			clear_row();
		end
		return hit;
	endfunction

	// ---------------------------------------------------------------
	// pixel sender
	// ---------------------------------------------------------------
	task automatic send_pixel(input pixel_beat_t b, input chk_kind_t chk,
			input centroid_beat_t typed);
		centroid_beat_t r;
		bit             hit;
		while ($urandom_range(99, 0) < idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.cur_pixel   <= b.cur_pixel;
		pix_ch.ref_pixel   <= b.ref_pixel;
		pix_ch.frame_start <= b.frame_start;
		pix_ch.row_end     <= b.row_end;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
		// beat taken at this edge
		hit = predict_centroid(b, r);
		case (chk)
			CHK_MODEL: if (hit) pending_centroids.insert(pending_centroids.size(), r);
			CHK_TYPED: pending_centroids.insert(pending_centroids.size(), typed);
			default: ;
		endcase
		items_sent++;
	endtask

	// drop valid and give it an edge, so the next beat never re-raises it
	// within the same step
	task automatic pixel_quiet();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending, let every owed centroid arrive, then let a row close that
	// makes no centroid run out as well
	task automatic settle();
		pixel_quiet();
		while (pending_centroids.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input pix_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		thr_reg = value;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic tbl_row(input int cur, input int refv, input bit fs, input bit re,
			input chk_kind_t chk, input int row, input int q4, input int rv);
		dir_row_t e;
		e.beat.cur_pixel         = pix_t'(cur);
		e.beat.ref_pixel         = pix_t'(refv);
		e.beat.frame_start       = fs;
		e.beat.row_end           = re;
		e.chk                    = chk;
		e.typed.row_index        = row_idx_t'(row);
		e.typed.centroid_q4      = cent_t'(q4);
		e.typed.ref_value        = pix_t'(rv);
		directed_tbl.insert(directed_tbl.size(), e);
	endtask

	// one laser-like row: background near the reference with a little noise,
	// up to two bright peaks, sometimes a frame start, sometimes pure noise
	task automatic send_random_row();
		pixel_beat_t b;
		int          len;
		int          fs_col;
		int          p1_at;
		int          p1_w;
		int          p2_at;
		int          p2_w;
		int          amp1;
		int          amp2;
		int          amp;
		int          refv;
		int          delta;
		int          c;
		bit          noise;
		bit          flat;
		len   = ($urandom_range(19, 0) == 0) ? $urandom_range(120, 25) : $urandom_range(24, 1);
		noise = $urandom_range(99, 0) < 15;
		case ($urandom_range(29, 0))
			0, 1, 2: fs_col = 0;
			3:       fs_col = $urandom_range(len - 1, 0);   // frame start mid-row
			default: fs_col = -1;
		endcase
		p1_at = $urandom_range(len - 1, 0);
		p1_w  = $urandom_range(6, 0);
		p2_at = $urandom_range(len - 1, 0);
		p2_w  = $urandom_range(1, 0) ? $urandom_range(6, 1) : 0;
		amp1  = $urandom_range(255, 1);
		// equal flat peaks make mean ties
		amp2  = ($urandom_range(3, 0) == 0) ? amp1 : $urandom_range(255, 1);
		flat  = $urandom_range(2, 0) == 0;
		for (c = 0; c < len; c++) begin
			b.frame_start = (c == fs_col);
			b.row_end     = (c == len - 1);
			if (noise) begin
				b.cur_pixel = pix_t'($urandom_range(255, 0));
				b.ref_pixel = pix_t'($urandom_range(255, 0));
			end else if ((c >= p1_at && c < p1_at + p1_w) || (c >= p2_at && c < p2_at + p2_w)) begin
				amp = (c >= p1_at && c < p1_at + p1_w) ? amp1 : amp2;
				if (!flat)
					amp = $urandom_range(amp, (amp + 1) / 2);
				refv        = $urandom_range(255 - amp, 0);
				b.ref_pixel = pix_t'(refv);
				b.cur_pixel = pix_t'(refv + amp);
			end else begin
				refv  = $urandom_range(255, 0);
				delta = $urandom_range(14, 0);
				b.ref_pixel = pix_t'(refv);
				if ($urandom_range(1, 0))
					b.cur_pixel = pix_t'((refv + delta > 255) ? 255 : refv + delta);
				else
					b.cur_pixel = pix_t'((refv < delta) ? 0 : refv - delta);
			end
			send_pixel(b, CHK_MODEL, '0);
		end
	endtask

	// one setting of threshold, sender idling and receiver stalling; the sender
	// pauses for a full drain halfway through
	task automatic run_phase(input pix_t thr, input int idle_p,
			input int stall_p, input int n_items, input bit with_hold);
		int unsigned target;
		int unsigned half;
		bit          paused;
		settle();
		write_threshold(thr);
		idle_pct  = idle_p;
		stall_pct = stall_p;
		if (with_hold)
			hold_req_cnt++;
		target = items_sent + n_items;
		half   = items_sent + n_items / 2;
		paused = 1'b0;
		while (items_sent < target) begin
			if (!paused && items_sent >= half) begin
				settle();
				paused = 1'b1;
			end
			send_random_row();
		end
	endtask

	// ---------------------------------------------------------------
	// centroid receiver: checks each beat, stalls at random, long holds
	// ---------------------------------------------------------------
	task automatic check_centroid();
		centroid_beat_t e;
		if (pending_centroids.size() == 0) begin
			$error("unexpected centroid beat: row_index %0d centroid_q4 %0d ref_value %0d",
				res_ch.row_index, res_ch.centroid_q4, res_ch.ref_value);
			fail_cnt++;
		end else begin
			e = pending_centroids[0];
			pending_centroids.delete(0);
			if (res_ch.row_index !== e.row_index) begin
				$error("row_index: expected %0d, got %0d", e.row_index, res_ch.row_index);
				fail_cnt++;
			end
			if (res_ch.centroid_q4 !== e.centroid_q4) begin
				$error("centroid_q4: expected %0d, got %0d", e.centroid_q4, res_ch.centroid_q4);
				fail_cnt++;
			end
			if (res_ch.ref_value !== e.ref_value) begin
				$error("ref_value: expected %0d, got %0d", e.ref_value, res_ch.ref_value);
				fail_cnt++;
			end
		end
	endtask

	initial begin
		int          hold_left;
		int unsigned hold_seen;
		hold_left = 0;
		hold_seen = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				check_centroid();
			if (hold_req_cnt != hold_seen) begin
				hold_seen = hold_req_cnt;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
			end
		end
	end

	// watchdog: any beat on any channel restarts the count
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		int          i;

		arst_n             <= 1'b0;
		pix_ch.valid       <= 1'b0;
		pix_ch.cur_pixel   <= '0;
		pix_ch.ref_pixel   <= '0;
		pix_ch.frame_start <= 1'b0;
		pix_ch.row_end     <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.data        <= '0;

		thr_reg = THR_DEFAULT;
		row_cnt = '0;
		clear_row();
		foreach (row_refs[k])
			row_refs[k] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at the reset threshold; comments give what each row checks
		// largest difference in column 0, one-pixel row
		tbl_row(255,   0, 1, 1, CHK_TYPED, 0, 0, 0);
		// current below reference: row without a cluster
		tbl_row(  0, 255, 0, 1, CHK_NONE,  0, 0, 0);
		// difference equal to the threshold does not count
		tbl_row( 20,  10, 0, 1, CHK_NONE,  0, 0, 0);
		// one above the threshold does
		tbl_row( 21,  10, 0, 1, CHK_TYPED, 3, 0, 10);
		// two clusters of equal mean: the first one wins
		tbl_row( 60,  10, 0, 0, CHK_MODEL, 0, 0, 0);
		tbl_row(  0,   0, 0, 0, CHK_MODEL, 0, 0, 0);
		tbl_row( 50,   0, 0, 1, CHK_TYPED, 4, 0, 10);
		// second cluster has the higher mean and runs into the row end
		tbl_row( 30,   0, 0, 0, CHK_MODEL, 0, 0, 0);
		tbl_row(  0,   5, 0, 0, CHK_MODEL, 0, 0, 0);
		tbl_row(200,   7, 0, 0, CHK_MODEL, 0, 0, 0);
		tbl_row(100,   9, 0, 1, CHK_MODEL, 0, 0, 0);
		// frame start mid-row drops the partial row and the row count
		tbl_row(255,   0, 0, 0, CHK_MODEL, 0, 0, 0);
		tbl_row(  0,   0, 1, 0, CHK_MODEL, 0, 0, 0);
		tbl_row(255,   3, 0, 1, CHK_TYPED, 0, 16, 3);
		// both pixels at full scale, then both at zero: no cluster
		tbl_row(255, 255, 0, 1, CHK_NONE,  0, 0, 0);
		tbl_row(  0,   0, 0, 1, CHK_NONE,  0, 0, 0);
		// weighted centroid between columns
		tbl_row( 11,   0, 0, 0, CHK_MODEL, 0, 0, 0);
		tbl_row(255, 128, 0, 0, CHK_MODEL, 0, 0, 0);
		tbl_row(128, 127, 0, 1, CHK_MODEL, 0, 0, 0);

		for (i = 0; i < directed_tbl.size(); i++)
			send_pixel(directed_tbl[i].beat, directed_tbl[i].chk, directed_tbl[i].typed);

		// random part: threshold extremes and middle values across idle and stall patterns
		run_phase(8'd0,                           0,  0, 250, 1'b1);
		run_phase(8'd255,                        48,  0, 100, 1'b0);
		run_phase(pix_t'($urandom_range(40, 1)),   0, 48, 250, 1'b1);
		run_phase(THR_DEFAULT,                    8,  8, 250, 1'b0);
		run_phase(pix_t'($urandom_range(254, 41)), 0,  0, 300, 1'b0);

		settle();
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
